/* src/sorted_string_set_unit_defines.svh */
// assertion macros shared by the checker
// no dependencies; uses clk and rst of the including scope
`ifndef SORTED_STRING_SET_UNIT_DEFINES_SVH
`define SORTED_STRING_SET_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssu_pkg.sv */
// shared types and constants of the sorted string set unit
// no dependencies
package ssu_pkg;

  localparam int CAP_CFG_W  = 9;
  localparam int STOR_CFG_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CAP_CFG_W-1:0]  CAP_RESET  = 9'd256;
  localparam logic [STOR_CFG_W-1:0] STOR_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STORAGE_LIMIT  = 1'b1;

  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    STS_FOUND     = 3'd0,
    STS_INSERTED  = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_NO_ROOM   = 3'd3,
    STS_TOO_LONG  = 3'd4,
    STS_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BS_CHECK, S_BS_LOAD, S_LS_CHECK, S_LS_LOAD, S_CMP_WAIT, S_CMP_EVAL,
    S_BS_RES, S_LS_RES, S_INS_CHECK, S_CP_READ, S_CP_WRITE, S_SORT_TEST,
    S_SI_CHECK, S_SI_LOAD, S_SJ_CHECK, S_SJ_LOAD, S_SJ_RES, S_PS_ISSUE,
    S_PS_EVAL, S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RET_BS, RET_LS, RET_SJ
  } ret_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_BYTE, DP_CLEAR, DP_OVF, DP_TERM, DP_BS_ISSUE, DP_LOAD_A,
    DP_CMP_STEP, DP_CMP_LATCH, DP_FOUND_MID, DP_BS_NARROW, DP_IDX_ISSUE,
    DP_FOUND_IDX, DP_IDX_NEXT, DP_NOTFOUND, DP_NOROOM, DP_CP_START,
    DP_CP_WRITE, DP_CP_FINISH, DP_SI_INIT, DP_SI_ISSUE, DP_SI_LOADV,
    DP_SJ_ISSUE, DP_SJ_LOADX, DP_SJ_SHIFT, DP_SJ_PLACE, DP_PS_INIT,
    DP_PS_FOUND, DP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic   in_ready;
    logic   cmp_stored;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_term;
    logic key_ovf;
    logic cmp_diff;
    logic cmp_end;
    logic cmp_eq;
    logic cmp_gt;
    logic bs_more;
    logic ls_more;
    logic op_insert;
    logic room;
    logic cp_more;
    logic tail_zero;
    logic si_more;
    logic j_nz;
    logic ps_hit;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/ssu_if.sv */
// request and result channel interfaces of the sorted string set unit
// depends on nothing; widths fixed by the field definitions
interface ssu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] key_byte;
  modport source (output valid, output operation, output key_byte, input ready);
  modport sink (input valid, input operation, input key_byte, output ready);
endinterface

interface ssu_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] position;
  logic [8:0] count;
  modport source (output valid, output status, output position, output count, input ready);
  modport sink (input valid, input status, input position, input count, output ready);
endinterface

/* src/ssu_datapath.sv */
// datapath: key buffer, string store, directory, search and sort registers
// depends on ssu_pkg
module ssu_datapath #(
  parameter int CAPACITY      = 256,
  parameter int STORAGE_BYTES = 4096,
  parameter int SLOP          = 16,
  parameter int MAX_KEY       = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ssu_pkg::dp_cmd_t                cmd,
  output ssu_pkg::dp_stat_t               stat,
  input  logic [1:0]                      in_operation,
  input  logic [7:0]                      in_key_byte,
  input  logic                            cfg_write,
  input  logic [ssu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssu_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [7:0]                      out_position,
  output logic [8:0]                      out_count
);
  import ssu_pkg::*;

  localparam int NW   = $clog2(CAPACITY + 1);
  localparam int DW   = $clog2(CAPACITY);
  localparam int AW   = $clog2(STORAGE_BYTES);
  localparam int UW   = $clog2(STORAGE_BYTES + 1);
  localparam int KLW  = $clog2(MAX_KEY + 1);
  localparam int KIW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int TW   = $clog2(SLOP + 1);
  localparam int LW   = (NW > CAP_CFG_W) ? NW : CAP_CFG_W;
  localparam int NDW0 = (UW > STOR_CFG_W) ? UW : STOR_CFG_W;
  localparam int NDW  = ((NDW0 > KLW) ? NDW0 : KLW) + 1;

  logic [7:0]    key_mem [MAX_KEY];
  logic [7:0]    store_mem [STORAGE_BYTES];
  logic [AW-1:0] dir_mem [CAPACITY];
  logic [7:0]    kb_rdata, st_rdata_a, st_rdata_b;
  logic [AW-1:0] dir_rdata;

  logic [CAP_CFG_W-1:0]  cap_limit;
  logic [STOR_CFG_W-1:0] stor_limit;
  logic [KLW-1:0] key_len;
  logic           key_ovf;
  logic [NW-1:0]  count;
  logic [UW-1:0]  used;
  logic [TW-1:0]  tail;
  logic [1:0]     op_reg;
  logic [NW-1:0]  lo, hi, mid, idx, si, j;
  logic [AW-1:0]  a_off, b_off, off_ins;
  logic [KLW-1:0] k;
  logic           cmp_eq, cmp_gt;
  status_t        res_status;
  logic [NW-1:0]  res_pos;

  logic [NW-1:0]  mid_comb, sorted;
  logic [NDW-1:0] need;
  logic [7:0]     aa, bb;
  logic           st_we, dir_we;
  logic [AW-1:0]  st_waddr, dir_wdata;
  logic [7:0]     st_wdata;
  logic [DW-1:0]  dir_waddr, dir_raddr;
  logic [NW-1:0]  j_dec;

  assign mid_comb = lo + ((hi - lo) >> 1);
  assign sorted   = count - NW'(tail);
  assign need     = NDW'(used) + NDW'(key_len) + NDW'(1);
  assign j_dec    = j - NW'(1);
  assign aa       = st_rdata_a;
  assign bb       = cmd.cmp_stored ? st_rdata_b : ((k < key_len) ? kb_rdata : 8'd0);

  // write and read port selection
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = off_ins + AW'(k);
    st_wdata  = kb_rdata;
    dir_we    = 1'b0;
    dir_waddr = j[DW-1:0];
    dir_wdata = a_off;
    dir_raddr = idx[DW-1:0];
    unique case (cmd.op)
      DP_CP_WRITE: st_we = 1'b1;
      DP_CP_FINISH: begin
        st_we     = 1'b1;
        st_waddr  = off_ins + AW'(key_len);
        st_wdata  = 8'd0;
        dir_we    = 1'b1;
        dir_waddr = count[DW-1:0];
        dir_wdata = off_ins;
      end
      DP_SJ_SHIFT: dir_we = 1'b1;
      DP_SJ_PLACE: begin
        dir_we    = 1'b1;
        dir_wdata = b_off;
      end
      DP_BS_ISSUE: dir_raddr = mid_comb[DW-1:0];
      DP_SI_ISSUE: dir_raddr = si[DW-1:0];
      DP_SJ_ISSUE: dir_raddr = j_dec[DW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_BYTE && key_len < KLW'(MAX_KEY)) key_mem[key_len[KIW-1:0]] <= in_key_byte;
    kb_rdata <= key_mem[k[KIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_a <= store_mem[a_off + AW'(k)];
    st_rdata_b <= store_mem[b_off + AW'(k)];
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rdata <= dir_mem[dir_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit  <= CAP_RESET;
      stor_limit <= STOR_RESET;
      key_len    <= '0;
      key_ovf    <= 1'b0;
      count      <= '0;
      used       <= '0;
      tail       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CAPACITY_LIMIT: cap_limit <= cfg_data[CAP_CFG_W-1:0];
          REG_STORAGE_LIMIT:  stor_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        DP_BYTE: begin
          if (key_len < KLW'(MAX_KEY)) key_len <= key_len + KLW'(1);
          else key_ovf <= 1'b1;
        end
        DP_CLEAR: begin
          count   <= '0;
          used    <= '0;
          tail    <= '0;
          key_len <= '0;
          key_ovf <= 1'b0;
        end
        DP_OVF, DP_FOUND_MID, DP_FOUND_IDX, DP_NOTFOUND, DP_NOROOM: begin
          key_len <= '0;
          key_ovf <= 1'b0;
        end
        DP_CP_FINISH: begin
          count   <= count + NW'(1);
          used    <= UW'(need);
          tail    <= (tail == TW'(SLOP - 1)) ? '0 : tail + TW'(1);
          key_len <= '0;
          key_ovf <= 1'b0;
        end
        default: ;
      endcase
      if (cmd.op == DP_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_CLEAR: begin
        res_status <= STS_CLEARED;
        res_pos    <= '0;
      end
      DP_OVF: begin
        res_status <= STS_TOO_LONG;
        res_pos    <= '0;
      end
      DP_TERM: begin
        op_reg <= in_operation;
        lo     <= '0;
        hi     <= sorted;
        idx    <= sorted;
      end
      DP_BS_ISSUE: mid <= mid_comb;
      DP_LOAD_A, DP_SJ_LOADX: begin
        a_off <= dir_rdata;
        k     <= '0;
      end
      DP_CMP_STEP, DP_CP_WRITE: k <= k + KLW'(1);
      DP_CMP_LATCH: begin
        cmp_eq <= (aa == bb);
        cmp_gt <= (aa > bb);
      end
      DP_FOUND_MID: begin
        res_status <= STS_FOUND;
        res_pos    <= mid;
      end
      DP_BS_NARROW: begin
        if (cmp_gt) hi <= mid;
        else lo <= mid + NW'(1);
      end
      DP_FOUND_IDX: begin
        res_status <= STS_FOUND;
        res_pos    <= idx;
      end
      DP_IDX_NEXT: idx <= idx + NW'(1);
      DP_NOTFOUND: begin
        res_status <= STS_NOT_FOUND;
        res_pos    <= '0;
      end
      DP_NOROOM: begin
        res_status <= STS_NO_ROOM;
        res_pos    <= '0;
      end
      DP_CP_START: begin
        k       <= '0;
        off_ins <= used[AW-1:0];
      end
      DP_CP_FINISH: begin
        res_status <= STS_INSERTED;
        res_pos    <= count;
      end
      DP_SI_INIT: si <= NW'(1);
      DP_SI_LOADV: begin
        b_off <= dir_rdata;
        j     <= si;
      end
      DP_SJ_SHIFT: j <= j_dec;
      DP_SJ_PLACE: si <= si + NW'(1);
      DP_PS_INIT: idx <= '0;
      DP_PS_FOUND: res_pos <= idx;
      DP_RESULT: begin
        out_status   <= res_status;
        out_position <= 8'(res_pos);
        out_count    <= 9'(count);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.in_clear  = (in_operation == OP_CLEAR);
    stat.in_term   = (in_key_byte == 8'd0);
    stat.key_ovf   = key_ovf;
    stat.cmp_diff  = (aa != bb);
    stat.cmp_end   = (bb == 8'd0);
    stat.cmp_eq    = cmp_eq;
    stat.cmp_gt    = cmp_gt;
    stat.bs_more   = (lo < hi);
    stat.ls_more   = (idx < count);
    stat.op_insert = (op_reg == OP_INSERT);
    stat.room      = (LW'(count) < LW'(cap_limit)) && (count < NW'(CAPACITY))
                     && (need < NDW'(stor_limit)) && (need < NDW'(STORAGE_BYTES));
    stat.cp_more   = (k < key_len);
    stat.tail_zero = (tail == '0);
    stat.si_more   = (si < count);
    stat.j_nz      = (j != '0);
    stat.ps_hit    = (dir_rdata == off_ins);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

/* src/ssu_controller.sv */
// controller state machine sequencing lookup, insert and re-sort
// depends on ssu_pkg
module ssu_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ssu_pkg::dp_stat_t stat,
  output ssu_pkg::dp_cmd_t  cmd
);
  import ssu_pkg::*;

  state_t state, state_next;
  ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_BS;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (stat.in_clear) state_next = S_RESULT;
          else if (!stat.in_term) state_next = S_IDLE;
          else if (stat.key_ovf) state_next = S_RESULT;
          else state_next = S_BS_CHECK;
        end
      end
      S_BS_CHECK: state_next = stat.bs_more ? S_BS_LOAD : S_LS_CHECK;
      S_BS_LOAD: begin
        ret_next   = RET_BS;
        state_next = S_CMP_WAIT;
      end
      S_LS_CHECK: begin
        priority if (stat.ls_more) state_next = S_LS_LOAD;
        else if (stat.op_insert) state_next = S_INS_CHECK;
        else state_next = S_RESULT;
      end
      S_LS_LOAD: begin
        ret_next   = RET_LS;
        state_next = S_CMP_WAIT;
      end
      S_CMP_WAIT: state_next = S_CMP_EVAL;
      S_CMP_EVAL: begin
        if (stat.cmp_diff || stat.cmp_end) begin
          unique case (ret)
            RET_BS:  state_next = S_BS_RES;
            RET_LS:  state_next = S_LS_RES;
            default: state_next = S_SJ_RES;
          endcase
        end else begin
          state_next = S_CMP_WAIT;
        end
      end
      S_BS_RES: state_next = stat.cmp_eq ? S_RESULT : S_BS_CHECK;
      S_LS_RES: state_next = stat.cmp_eq ? S_RESULT : S_LS_CHECK;
      S_INS_CHECK: state_next = stat.room ? S_CP_READ : S_RESULT;
      S_CP_READ: state_next = stat.cp_more ? S_CP_WRITE : S_SORT_TEST;
      S_CP_WRITE: state_next = S_CP_READ;
      S_SORT_TEST: state_next = stat.tail_zero ? S_SI_CHECK : S_RESULT;
      S_SI_CHECK: state_next = stat.si_more ? S_SI_LOAD : S_PS_ISSUE;
      S_SI_LOAD: state_next = S_SJ_CHECK;
      S_SJ_CHECK: state_next = stat.j_nz ? S_SJ_LOAD : S_SI_CHECK;
      S_SJ_LOAD: begin
        ret_next   = RET_SJ;
        state_next = S_CMP_WAIT;
      end
      S_SJ_RES: state_next = stat.cmp_gt ? S_SJ_CHECK : S_SI_CHECK;
      S_PS_ISSUE: state_next = S_PS_EVAL;
      S_PS_EVAL: state_next = stat.ps_hit ? S_RESULT : S_PS_ISSUE;
      S_RESULT: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready   = (state == S_IDLE);
    cmd.cmp_stored = (ret == RET_SJ);
    cmd.op         = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (stat.in_clear) cmd.op = DP_CLEAR;
          else if (!stat.in_term) cmd.op = DP_BYTE;
          else if (stat.key_ovf) cmd.op = DP_OVF;
          else cmd.op = DP_TERM;
        end
      end
      S_BS_CHECK: if (stat.bs_more) cmd.op = DP_BS_ISSUE;
      S_BS_LOAD, S_LS_LOAD: cmd.op = DP_LOAD_A;
      S_LS_CHECK: begin
        priority if (stat.ls_more) cmd.op = DP_IDX_ISSUE;
        else if (!stat.op_insert) cmd.op = DP_NOTFOUND;
        else cmd.op = DP_NOP;
      end
      S_CMP_EVAL: cmd.op = (stat.cmp_diff || stat.cmp_end) ? DP_CMP_LATCH : DP_CMP_STEP;
      S_BS_RES: cmd.op = stat.cmp_eq ? DP_FOUND_MID : DP_BS_NARROW;
      S_LS_RES: cmd.op = stat.cmp_eq ? DP_FOUND_IDX : DP_IDX_NEXT;
      S_INS_CHECK: cmd.op = stat.room ? DP_CP_START : DP_NOROOM;
      S_CP_READ: if (!stat.cp_more) cmd.op = DP_CP_FINISH;
      S_CP_WRITE: cmd.op = DP_CP_WRITE;
      S_SORT_TEST: if (stat.tail_zero) cmd.op = DP_SI_INIT;
      S_SI_CHECK: cmd.op = stat.si_more ? DP_SI_ISSUE : DP_PS_INIT;
      S_SI_LOAD: cmd.op = DP_SI_LOADV;
      S_SJ_CHECK: cmd.op = stat.j_nz ? DP_SJ_ISSUE : DP_SJ_PLACE;
      S_SJ_LOAD: cmd.op = DP_SJ_LOADX;
      S_SJ_RES: cmd.op = stat.cmp_gt ? DP_SJ_SHIFT : DP_SJ_PLACE;
      S_PS_ISSUE: cmd.op = DP_IDX_ISSUE;
      S_PS_EVAL: cmd.op = stat.ps_hit ? DP_PS_FOUND : DP_IDX_NEXT;
      S_RESULT: if (stat.out_free) cmd.op = DP_RESULT;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

/* src/sorted_string_set_unit.sv */
// key bytes: one request per cycle, no result; clear or too-long key: result once output is free
// terminator: binary search then tail scan, each probe a byte-by-byte compare with the key
// insert copies the key to the store; every SLOP-th insert insertion-sorts the directory
// (up to n*n/2 string compares on one directory port) plus a position scan of up to n reads
// sync active-high reset clears counts, resets limits; stores hold garbage until written, no sweep
module sorted_string_set_unit #(
  parameter int CAPACITY      = 256,
  parameter int STORAGE_BYTES = 4096,
  parameter int SLOP          = 16,
  parameter int MAX_KEY       = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  ssu_in_if.sink                         request,
  ssu_out_if.source                      result,
  input  logic                           cfg_write,
  input  logic [ssu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign request.ready = cmd.in_ready;

  ssu_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssu_datapath #(
    .CAPACITY      (CAPACITY),
    .STORAGE_BYTES (STORAGE_BYTES),
    .SLOP          (SLOP),
    .MAX_KEY       (MAX_KEY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (request.operation),
    .in_key_byte  (request.key_byte),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_position (result.position),
    .out_count    (result.count)
  );

endmodule

/* src/ssu_checker.sv */
// port-level checker of the sorted string set unit, bound to the top level
// depends on ssu_pkg and sorted_string_set_unit_defines.svh
`include "sorted_string_set_unit_defines.svh"

module ssu_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_status,
  input logic [7:0] res_position,
  input logic [8:0] res_count
);
  import ssu_pkg::*;

  `SSU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_position) && $stable(res_count), "stalled result changed")
  `SSU_ASSERT_NOW(a_clear_empty, res_valid && res_status == STS_CLEARED, res_count == 9'd0 && res_position == 8'd0, "clear left strings")
  `SSU_ASSERT_NOW(a_pos_in_set, res_valid && (res_status == STS_FOUND || res_status == STS_INSERTED), res_position < res_count, "position beyond count")
  `SSU_ASSERT_NOW(a_pos_zero, res_valid && (res_status == STS_NOT_FOUND || res_status == STS_NO_ROOM || res_status == STS_TOO_LONG), res_position == 8'd0, "position not zero")

endmodule

bind sorted_string_set_unit ssu_checker u_ssu_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_status   (result.status),
  .res_position (result.position),
  .res_count    (result.count)
);
